// ===== rtl/ipv6_tap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_tap_pkg
// Types and constants shared by the IPv6 text address parser.
// ----------------------------------------------------------------------------
package ipv6_tap_pkg;

    localparam int GROUPS      = 8;
    localparam int GROUP_W     = 16;
    localparam int GIDX_W      = 3;
    localparam int GCNT_W      = 4;
    localparam int DCNT_W      = 3;
    localparam int ADDR_HALF_W = 64;

    localparam logic [7:0]        CHAR_COLON  = 8'h3A;
    localparam logic [DCNT_W-1:0] LONG_DIGITS = 3'd5;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_CHAR   = 2'd1,
        ST_LONG_GROUP = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } item_t;

    typedef struct packed {
        logic [ADDR_HALF_W-1:0] addr_high;
        logic [ADDR_HALF_W-1:0] addr_low;
        status_t                status;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            h.value = 4'(c - 8'd48);
        end
        else if (c >= "a" && c <= "f")
        begin
            h.value = 4'(c - "a" + 8'd10);
        end
        else if (c >= "A" && c <= "F")
        begin
            h.value = 4'(c - "A" + 8'd10);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ipv6_text_address_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_text_address_parser
// Parses IPv6 address text, one character per word, into a 128-bit address.
// ----------------------------------------------------------------------------
// Takes one ASCII character per cycle; the word flagged tlast closes the
// address, and an output word from the result register carries the
// address and a status (0 ok, 1 bad character, 2 group longer than four
// digits; address zero on error). Each character passes an input register
// and one stage of decode and group logic; a final one also fills the
// result register. Non-final characters never wait on the output side; the
// final one waits only while an unread result sits in the result register.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser
    import ipv6_tap_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] char_code
    input  wire logic         s_axis_tlast,   // last_char
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata    // [63:0] addr_high, [127:64] addr_low,
                                              // [129:128] status, [135:130] zero
);

    item_t   in_item;
    item_t   item;
    logic    fire;
    logic    out_free;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.char_code = s_axis_tdata;
    assign in_item.last_char = s_axis_tlast;

    ipv6_tap_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .out_free (out_free),
        .fire     (fire),
        .item     (item)
    );

    ipv6_tap_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    ipv6_tap_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.status, out_res.addr_low, out_res.addr_high};

endmodule
`default_nettype wire

// ===== rtl/ipv6_tap_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_tap_in_stage
// Input register; one character a cycle to the core unless a last one waits.
// ----------------------------------------------------------------------------
module ipv6_tap_in_stage
    import ipv6_tap_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  out_free,
    output logic       fire,
    output item_t      item
);

    logic  valid_reg;
    item_t item_reg;

    // last character needs the result register free
    assign fire     = valid_reg && (!item_reg.last_char || out_free);
    assign in_ready = !valid_reg || fire;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ipv6_tap_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_tap_core
// Group collection state and address assembly for one character a cycle.
// ----------------------------------------------------------------------------
module ipv6_tap_core
    import ipv6_tap_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    output logic       res_valid,
    output result_t    res
);

    typedef struct packed {
        logic              wr_left;
        logic              wr_right;
        logic [GCNT_W-1:0] lc;
        logic [GCNT_W-1:0] rc;
        logic              full;
    } push_t;

    logic [GROUP_W-1:0] left_reg  [GROUPS];
    logic [GROUP_W-1:0] left_next [GROUPS];
    // right groups, most recent at index 0
    logic [GROUP_W-1:0] rq_reg    [GROUPS];
    logic [GROUP_W-1:0] rq_next   [GROUPS];

    logic [GROUP_W-1:0] gv_reg, gv_next;
    logic [DCNT_W-1:0]  dc_reg, dc_next;
    logic [GCNT_W-1:0]  lc_reg, lc_next;
    logic [GCNT_W-1:0]  rc_reg, rc_next;
    logic               cm_reg, cm_next;
    logic               ad_reg, ad_next;
    logic               full_reg, full_next;
    status_t            err_reg, err_next;

    function automatic push_t push_calc(input logic ad, input logic [GCNT_W-1:0] lc,
                                        input logic [GCNT_W-1:0] rc);
        push_t              p;
        logic [GCNT_W:0]    sum;
        p     = '0;
        p.lc  = lc;
        p.rc  = rc;
        sum   = {1'b0, lc} + {1'b0, rc};
        if (ad)
        begin
            if (sum < (GCNT_W+1)'(GROUPS))
            begin
                p.wr_right = 1'b1;
                p.rc       = rc + 1'b1;
                sum        = sum + 1'b1;
            end
            p.full = (sum >= (GCNT_W+1)'(GROUPS - 1));
        end
        else
        begin
            if (lc < GCNT_W'(GROUPS))
            begin
                p.wr_left = 1'b1;
                p.lc      = lc + 1'b1;
            end
            p.full = (p.lc >= GCNT_W'(GROUPS));
        end
        return p;
    endfunction

    always_comb
    begin
        hex_t               dec;
        push_t              pr;
        logic               active;
        logic               stopped;
        logic               do_left;
        logic               do_right;
        logic [GIDX_W-1:0]  widx;
        logic [GROUP_W-1:0] pv;
        logic [GCNT_W:0]    rpos;
        logic [GROUP_W-1:0] w;
        logic [2*ADDR_HALF_W-1:0] addr;

        gv_next   = gv_reg;
        dc_next   = dc_reg;
        lc_next   = lc_reg;
        rc_next   = rc_reg;
        cm_next   = cm_reg;
        ad_next   = ad_reg;
        full_next = full_reg;
        err_next  = err_reg;
        dec       = hex_decode(item.char_code);
        pr        = '0;
        active    = fire && !full_reg && (err_reg == ST_OK);
        stopped   = 1'b0;
        do_left   = 1'b0;
        do_right  = 1'b0;
        widx      = '0;
        pv        = gv_reg;
        addr      = '0;

        if (active)
        begin
            if (item.char_code == CHAR_COLON)
            begin
                if (dc_reg != '0)
                begin
                    pr        = push_calc(ad_reg, lc_reg, rc_reg);
                    do_left   = pr.wr_left;
                    do_right  = pr.wr_right;
                    widx      = lc_reg[GIDX_W-1:0];
                    pv        = gv_reg;
                    lc_next   = pr.lc;
                    rc_next   = pr.rc;
                    full_next = full_reg | pr.full;
                    stopped   = full_next;
                end
                if (!stopped)
                begin
                    if (cm_reg)
                    begin
                        ad_next = 1'b1;
                    end
                    cm_next = 1'b1;
                    gv_next = '0;
                    dc_next = '0;
                end
            end
            else if (!dec.ok)
            begin
                err_next = ST_BAD_CHAR;
            end
            else
            begin
                gv_next = {gv_reg[GROUP_W-5:0], dec.value};
                dc_next = dc_reg + 1'b1;
                cm_next = 1'b0;
                if (dc_next == LONG_DIGITS)
                begin
                    err_next = ST_LONG_GROUP;
                end
            end
        end

        if (fire && item.last_char && !full_next && (err_next == ST_OK) && (dc_next != '0))
        begin
            pr        = push_calc(ad_next, lc_next, rc_next);
            do_left   = pr.wr_left;
            do_right  = pr.wr_right;
            widx      = lc_next[GIDX_W-1:0];
            pv        = gv_next;
            lc_next   = pr.lc;
            rc_next   = pr.rc;
            full_next = full_next | pr.full;
        end

        for (int i = 0; i < GROUPS; i++)
        begin
            left_next[i] = left_reg[i];
            rq_next[i]   = rq_reg[i];
        end
        if (do_left)
        begin
            left_next[widx] = pv;
        end
        if (do_right)
        begin
            rq_next[0] = pv;
            for (int i = 1; i < GROUPS; i++)
            begin
                rq_next[i] = rq_reg[i-1];
            end
        end

        for (int g = 0; g < GROUPS; g++)
        begin
            rpos = {1'b0, rc_next} + (GCNT_W+1)'(g);
            w    = '0;
            if (GCNT_W'(g) < lc_next)
            begin
                w = left_next[g];
            end
            else if (rpos >= (GCNT_W+1)'(GROUPS))
            begin
                w = rq_next[GROUPS-1-g];
            end
            addr[2*ADDR_HALF_W-1-GROUP_W*g -: GROUP_W] = w;
        end
        if (err_next != ST_OK)
        begin
            addr = '0;
        end

        res_valid     = fire && item.last_char;
        res.addr_high = addr[2*ADDR_HALF_W-1:ADDR_HALF_W];
        res.addr_low  = addr[ADDR_HALF_W-1:0];
        res.status    = err_next;

        if (res_valid)
        begin
            gv_next   = '0;
            dc_next   = '0;
            lc_next   = '0;
            rc_next   = '0;
            cm_next   = 1'b0;
            ad_next   = 1'b0;
            full_next = 1'b0;
            err_next  = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gv_reg   <= '0;
            dc_reg   <= '0;
            lc_reg   <= '0;
            rc_reg   <= '0;
            cm_reg   <= 1'b0;
            ad_reg   <= 1'b0;
            full_reg <= 1'b0;
            err_reg  <= ST_OK;
        end
        else
        begin
            gv_reg   <= gv_next;
            dc_reg   <= dc_next;
            lc_reg   <= lc_next;
            rc_reg   <= rc_next;
            cm_reg   <= cm_next;
            ad_reg   <= ad_next;
            full_reg <= full_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < GROUPS; i++)
        begin
            left_reg[i] <= left_next[i];
            rq_reg[i]   <= rq_next[i];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ipv6_tap_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_tap_out_stage
// Result register holding one address word until taken.
// ----------------------------------------------------------------------------
module ipv6_tap_out_stage
    import ipv6_tap_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         out_free,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv6 text address parser.
// ----------------------------------------------------------------------------
// Characters go in as stream words and 128-bit addresses come out. Every
// accepted character goes through a behavioural copy of the parser, and each
// address it predicts is queued. Output words are compared field by field
// against that queue. The stimulus starts with a few hand-picked addresses.
// Random ones follow: mostly well-formed addresses with or without a double
// colon, some deliberately broken, some pure noise. Both ports idle and stall
// at random. The sink also holds off for one long stretch, and the source
// pauses once until the output side has drained.
// ----------------------------------------------------------------------------
module tb_top;
    import ipv6_tap_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LIVE_CHARS  = 1500;
    localparam int LONG_HOLD   = 400;

    class addr_scoreboard;
        logic [GROUP_W-1:0] left_grp [GROUPS];
        logic [GROUP_W-1:0] right_grp [GROUPS];
        logic [GROUP_W-1:0] grp_val;
        int                 digits;
        int                 n_left;
        int                 n_right;
        bit                 colon_seen;
        bit                 past_double;
        bit                 addr_full;
        status_t            err;
        result_t            pending_addrs[$];
        int                 n_errors;
        int                 n_checked;
        int                 n_live;
        int                 n_status [4];

        function new();
            n_errors  = 0;
            n_checked = 0;
            n_live    = 0;
            foreach (n_status[i])
            begin
                n_status[i] = 0;
            end
            clear();
        endfunction

        function void clear();
            foreach (left_grp[i])
            begin
                left_grp[i]  = '0;
                right_grp[i] = '0;
            end
            grp_val     = '0;
            digits      = 0;
            n_left      = 0;
            n_right     = 0;
            colon_seen  = 1'b0;
            past_double = 1'b0;
            addr_full   = 1'b0;
            err         = ST_OK;
        endfunction

        function int hex_nibble(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39)
            begin
                return int'(c) - 48;
            end
            if (c >= 8'h61 && c <= 8'h66)
            begin
                return int'(c) - 8'h61 + 10;
            end
            if (c >= 8'h41 && c <= 8'h46)
            begin
                return int'(c) - 8'h41 + 10;
            end
            return -1;
        endfunction

        function void push_group();
            if (past_double)
            begin
                if (n_left + n_right < GROUPS)
                begin
                    right_grp[n_right] = grp_val;
                    n_right++;
                end
                if (n_left + n_right >= GROUPS - 1)
                begin
                    addr_full = 1'b1;
                end
            end
            else
            begin
                if (n_left < GROUPS)
                begin
                    left_grp[n_left] = grp_val;
                    n_left++;
                end
                if (n_left >= GROUPS)
                begin
                    addr_full = 1'b1;
                end
            end
        endfunction

        function void note_char(logic [7:0] c, logic last);
            int                 d;
            int                 rstart;
            bit                 stopped;
            logic [GROUP_W-1:0] g16;
            result_t            res;
            if ((!addr_full && err == ST_OK) || last)
            begin
                n_live++;
            end
            if (!addr_full && err == ST_OK)
            begin
                if (c == CHAR_COLON)
                begin
                    stopped = 1'b0;
                    if (digits > 0)
                    begin
                        push_group();
                        stopped = addr_full;
                    end
                    if (!stopped)
                    begin
                        if (colon_seen)
                        begin
                            past_double = 1'b1;
                        end
                        colon_seen = 1'b1;
                        grp_val    = '0;
                        digits     = 0;
                    end
                end
                else
                begin
                    d = hex_nibble(c);
                    if (d < 0)
                    begin
                        err = ST_BAD_CHAR;
                    end
                    else
                    begin
                        grp_val    = {grp_val[GROUP_W-5:0], 4'(d)};
                        digits++;
                        colon_seen = 1'b0;
                        if (digits == 5)
                        begin
                            err = ST_LONG_GROUP;
                        end
                    end
                end
            end
            if (!last)
            begin
                return;
            end
            if (!addr_full && err == ST_OK && digits > 0)
            begin
                push_group();
            end
            res.addr_high = '0;
            res.addr_low  = '0;
            res.status    = err;
            if (err == ST_OK)
            begin
                rstart = GROUPS - n_right;
                for (int g = 0; g < GROUPS; g++)
                begin
                    g16 = '0;
                    if (g < n_left)
                    begin
                        g16 = left_grp[g];
                    end
                    else if (g >= rstart)
                    begin
                        g16 = right_grp[g - rstart];
                    end
                    if (g < 4)
                    begin
                        res.addr_high[63 - 16*g -: 16] = g16;
                    end
                    else
                    begin
                        res.addr_low[63 - 16*(g-4) -: 16] = g16;
                    end
                end
            end
            pending_addrs.push_back(res);
            clear();
        endfunction

        function void note_mismatch(string msg);
            n_errors++;
            if (n_errors <= 10)
            begin
                $display("ERROR result %0d: %s", n_checked, msg);
            end
        endfunction

        function void field_check(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                note_mismatch($sformatf("%s expected %h got %h", name, want, got));
            end
        endfunction

        function void check_addr_word(logic [135:0] w);
            result_t want;
            if (pending_addrs.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result word %h", w));
                return;
            end
            want = pending_addrs.pop_front();
            n_checked++;
            n_status[want.status]++;
            field_check("addr_high", want.addr_high, w[63:0]);
            field_check("addr_low", want.addr_low, w[127:64]);
            field_check("status", 64'(want.status), 64'(w[129:128]));
            field_check("padding", 64'(0), 64'(w[135:130]));
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;

    addr_scoreboard sb;
    logic [7:0]     text_q[$];
    bit             no_gaps;
    bit             long_hold_req;
    int             cycles;

    ipv6_text_address_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_addr_word(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_char(s_axis_tdata, s_axis_tlast);
            end
        end
    end

    // sink: random stalls, quiet stretches, one long hold-off on request
    initial
    begin : result_sink
        int hold;
        int steady;
        int r;
        hold          = 0;
        steady        = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold          = LONG_HOLD;
            end
            if (hold > 0)
            begin
                m_axis_tready = 1'b0;
                hold--;
            end
            else if (steady > 0)
            begin
                m_axis_tready = 1'b1;
                steady--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                m_axis_tready = (r < 70);
                if (r < 3)
                begin
                    steady = $urandom_range(50, 200);
                end
                else if (r >= 95)
                begin
                    hold = $urandom_range(15, 50);
                end
                else if (r >= 70)
                begin
                    hold = $urandom_range(0, 3);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tlast  = last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return 8'(8'h30 + v);
        end
        return $urandom_range(0, 1) ? 8'(8'h61 + v - 10) : 8'(8'h41 + v - 10);
    endfunction

    function automatic void add_group(int nd);
        repeat (nd) text_q.push_back(rand_hex_char());
    endfunction

    function automatic void make_address();
        int kind;
        int ngrp;
        int dpos;
        int pos;
        text_q.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 2)
        begin
            ngrp = $urandom_range(1, 9);
            for (int g = 0; g < ngrp; g++)
            begin
                if (g > 0)
                begin
                    text_q.push_back(CHAR_COLON);
                end
                add_group($urandom_range(1, 4));
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (kind <= 7)
        begin
            ngrp = $urandom_range(0, 8);
            dpos = $urandom_range(0, ngrp);
            for (int g = 0; g < ngrp; g++)
            begin
                if (g == dpos)
                begin
                    text_q.push_back(CHAR_COLON);
                    text_q.push_back(CHAR_COLON);
                end
                else if (g > 0)
                begin
                    text_q.push_back(CHAR_COLON);
                end
                add_group($urandom_range(1, 4));
            end
            if (dpos == ngrp)
            begin
                text_q.push_back(CHAR_COLON);
                text_q.push_back(CHAR_COLON);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                text_q.push_back(CHAR_COLON);
                text_q.push_back(CHAR_COLON);
                add_group($urandom_range(1, 4));
            end
            // broken variant: stray byte, stray colon or a five-digit group
            if (kind == 7)
            begin
                pos = $urandom_range(0, text_q.size() - 1);
                case ($urandom_range(0, 2))
                    0: text_q[pos] = 8'($urandom_range(0, 255));
                    1: text_q.insert(pos, CHAR_COLON);
                    default:
                    begin
                        repeat (5) text_q.push_front(rand_hex_char());
                    end
                endcase
            end
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 10))
            begin
                text_q.push_back($urandom_range(0, 1) ? CHAR_COLON : rand_hex_char());
            end
        end
    endfunction

    initial
    begin : stimulus
        int n_addr;
        int n_chars;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        long_hold_req = 1'b0;
        no_gaps       = 1'b0;
        n_addr        = 0;
        n_chars       = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        send_text("aF09::Bc");
        send_text("12345");
        send_char(8'hFF, 1'b1);
        send_text("1::2::3");
        send_text(":::");
        send_char(8'h00, 1'b1);

        while (sb.n_live < LIVE_CHARS)
        begin
            make_address();
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < text_q.size(); i++)
            begin
                send_char(text_q[i], i == text_q.size() - 1);
            end
            n_chars += text_q.size();
            n_addr++;
            if (n_addr == 20)
            begin
                long_hold_req = 1'b1;
            end
            if (n_addr == 45)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                while (sb.pending_addrs.size() != 0)
                begin
                    @(posedge clk);
                end
            end
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;

        while (sb.pending_addrs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (sb.pending_addrs.size() != 0)
        begin
            sb.note_mismatch($sformatf("%0d addresses never came out",
                                       sb.pending_addrs.size()));
        end

        $display("Sent %0d random addresses (%0d chars) after the directed set; %0d results checked",
                 n_addr, n_chars, sb.n_checked);
        $display("Status mix: %0d ok, %0d bad character, %0d long group; %0d mismatches",
                 sb.n_status[ST_OK], sb.n_status[ST_BAD_CHAR], sb.n_status[ST_LONG_GROUP],
                 sb.n_errors);
        if (sb.n_errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
